>>> sv/cvmsf_pkg.sv
`default_nettype none
package cvmsf_pkg;

   // Fixed frame geometry.
   localparam int CHANNELS      = 8;
   localparam int SAMPLE_W      = 16;
   localparam int CH_W          = $clog2(CHANNELS);
   localparam int CNT_W         = $clog2(CHANNELS + 1);
   localparam int BLOCK_LEN_DEF = 64;

   // Upper clamp of a selection sum, floor(0.999 * 32768).
   localparam int SEL_MAX = 32735;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IN_OFS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_OFS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SOFT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IN_MASK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MASK = 3'd5;

   // Routing decisions that travel with a frame down to the output merge.
   typedef struct packed {
      logic [CH_W-1:0] cur_dest;
      logic [CH_W-1:0] prev_dest;
      logic            cur_en;
      logic            prev_en;
      logic            add_old;
   } route_ctl_type;

   // Load strobes for the two registered steps inside a gain lane.
   typedef struct packed {
      logic load_b;
      logic load_c;
   } stage_en_type;

endpackage
`default_nettype wire

>>> sv/cvmsf_pick.sv
`default_nettype none
module cvmsf_pick (
   input  wire logic signed [cvmsf_pkg::SAMPLE_W-1:0] offset_i,
   input  wire logic signed [cvmsf_pkg::SAMPLE_W-1:0] cv_i,
   input  wire logic [cvmsf_pkg::CHANNELS-1:0]        mask_i,
   input  wire logic                                  active_only_i,
   output logic [cvmsf_pkg::CH_W-1:0]                 chan_o
);
   import cvmsf_pkg::*;

   localparam logic signed [SAMPLE_W:0] SEL_HI = (SAMPLE_W + 1)'(SEL_MAX);
   localparam int PROD_W = SAMPLE_W + CNT_W;

   logic signed [SAMPLE_W:0] sum;
   logic [SAMPLE_W-1:0]      clamped;
   logic [SAMPLE_W-1:0]      unsigned_sel;
   logic [CNT_W-1:0]         count;
   logic [CNT_W-1:0]         scale;
   logic [PROD_W-1:0]        prod;
   logic [CNT_W-1:0]         idx;
   logic [CNT_W-1:0]         seen;
   logic                     found;

   // Add the knob offset and clamp to the selection range.
   always_comb begin
      sum = {offset_i[SAMPLE_W-1], offset_i} + {cv_i[SAMPLE_W-1], cv_i};
      if (sum[SAMPLE_W] && !sum[SAMPLE_W-1]) begin
         clamped = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      end else if (!sum[SAMPLE_W] && (sum > SEL_HI)) begin
         clamped = SEL_HI[SAMPLE_W-1:0];
      end else begin
         clamped = sum[SAMPLE_W-1:0];
      end
      // Offset binary: adds 32768 to the clamped value.
      unsigned_sel = {~clamped[SAMPLE_W-1], clamped[SAMPLE_W-2:0]};
   end

   // Scale the selection to an index over all or over the enabled channels.
   always_comb begin
      count = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         count = count + CNT_W'(mask_i[c]);
      end
      scale = active_only_i ? count : CNT_W'(CHANNELS);
      prod  = PROD_W'(unsigned_sel) * PROD_W'(scale);
      idx   = prod[PROD_W-1 -: CNT_W];
   end

   // In active-only mode the index names the k-th enabled channel.
   always_comb begin
      seen  = '0;
      found = 1'b0;
      chan_o = '0;
      if (!active_only_i) begin
         chan_o = idx[CH_W-1:0];
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (mask_i[c]) begin
               if (!found && (seen == idx)) begin
                  chan_o = CH_W'(c);
                  found  = 1'b1;
               end
               seen = seen + 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> sv/cvmsf_lane.sv
`default_nettype none
module cvmsf_lane #(
   parameter int BLOCK_LEN = cvmsf_pkg::BLOCK_LEN_DEF
) (
   input  wire logic                                  clock,
   input  wire cvmsf_pkg::stage_en_type               en_i,
   input  wire logic signed [cvmsf_pkg::SAMPLE_W-1:0] sample_i,
   input  wire logic [$clog2(BLOCK_LEN / 2 + 1)-1:0]  num_i,
   output logic signed [cvmsf_pkg::SAMPLE_W:0]        value_o
);
   import cvmsf_pkg::*;

   // The gain is num / HALF. The division by HALF is a multiply by a rounded-up
   // reciprocal, exact for every product below 2**PROD_W.
   localparam int HALF    = BLOCK_LEN / 2;
   localparam int NUM_W   = $clog2(HALF + 1);
   localparam int PROD_W  = SAMPLE_W + NUM_W;
   localparam int SHIFT   = PROD_W + $clog2(HALF);
   localparam int RECIP_W = PROD_W + 2;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) + 64'(HALF) - 64'd1) / 64'(HALF);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic [SAMPLE_W-1:0]         mag;
   logic [PROD_W-1:0]           prod_in;
   logic [PROD_W-1:0]           prod_ff;
   logic                        sign_b_ff;
   logic [PROD_W+RECIP_W-1:0]   wide;
   logic [SAMPLE_W-1:0]         quot_in;
   logic [SAMPLE_W-1:0]         quot_ff;
   logic                        sign_c_ff;

   // Magnitude times gain numerator.
   always_comb begin
      mag     = sample_i[SAMPLE_W-1] ? SAMPLE_W'(-sample_i) : SAMPLE_W'(sample_i);
      prod_in = PROD_W'(mag) * PROD_W'(num_i);
   end

   always_ff @(posedge clock) begin
      if (en_i.load_b) begin
         prod_ff   <= prod_in;
         sign_b_ff <= sample_i[SAMPLE_W-1];
      end
   end

   // Divide by the half-block length through the reciprocal.
   always_comb begin
      wide    = (PROD_W + RECIP_W)'(prod_ff) * (PROD_W + RECIP_W)'(RECIP);
      quot_in = wide[SHIFT +: SAMPLE_W];
   end

   always_ff @(posedge clock) begin
      if (en_i.load_c) begin
         quot_ff   <= quot_in;
         sign_c_ff <= sign_b_ff;
      end
   end

   // Restore the sign, truncating toward zero.
   always_comb begin
      value_o = sign_c_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
   end

endmodule
`default_nettype wire

>>> sv/cvmsf_merge.sv
`default_nettype none
module cvmsf_merge (
   input  wire logic signed [cvmsf_pkg::SAMPLE_W:0]           new_val_i,
   input  wire logic signed [cvmsf_pkg::SAMPLE_W:0]           old_val_i,
   input  wire cvmsf_pkg::route_ctl_type                      ctl_i,
   output logic [cvmsf_pkg::CHANNELS*cvmsf_pkg::SAMPLE_W-1:0] frame_o
);
   import cvmsf_pkg::*;

   localparam logic signed [SAMPLE_W+1:0] POS_LIM = (SAMPLE_W + 2)'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [SAMPLE_W+1:0] NEG_LIM = -(SAMPLE_W + 2)'(2 ** (SAMPLE_W - 1));

   function automatic logic [SAMPLE_W-1:0] sat(input logic signed [SAMPLE_W+1:0] v);
      logic [SAMPLE_W-1:0] r;
      if (v > POS_LIM) begin
         r = POS_LIM[SAMPLE_W-1:0];
      end else if (v < NEG_LIM) begin
         r = NEG_LIM[SAMPLE_W-1:0];
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   logic signed [SAMPLE_W+1:0] cur_sum;
   logic signed [SAMPLE_W+1:0] old_ext;
   logic [SAMPLE_W-1:0]        cur_out;
   logic [SAMPLE_W-1:0]        old_out;

   // The new route, with the fading old route mixed in on a source change.
   always_comb begin
      old_ext = {old_val_i[SAMPLE_W], old_val_i};
      cur_sum = {new_val_i[SAMPLE_W], new_val_i} + (ctl_i.add_old ? old_ext : '0);
      cur_out = sat(cur_sum);
      old_out = sat(old_ext);
   end

   // Place both routes on their output channels; all others are silent.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         frame_o[c*SAMPLE_W +: SAMPLE_W] = '0;
         if (ctl_i.cur_en && (ctl_i.cur_dest == CH_W'(c))) begin
            frame_o[c*SAMPLE_W +: SAMPLE_W] = cur_out;
         end
         if (ctl_i.prev_en && (ctl_i.prev_dest == CH_W'(c))) begin
            frame_o[c*SAMPLE_W +: SAMPLE_W] = old_out;
         end
      end
   end

endmodule
`default_nettype wire

>>> sv/cv_matrix_switch_soft_fade.sv
// Eight-channel sequential audio switch with optional crossfade.
// Input stream req_*: one audio frame per transfer, eight samples and two
// selection voltages. Output stream rsp_*: one frame of eight samples per
// input frame, in order; only the routed output channel carries signal, and during a fade also the old route's channel.
// Configuration: csr_wr_en writes csr_wdata into the register csr_index
// (offsets, active-only, soft mode, enable masks); write while idle only.
// The route is picked from the voltages on the first frame of each block of
// BLOCK_LEN frames; in soft mode a route change fades the old route out over
// the first half-block and the new route in over the second half.
// An accepted frame passes the input register, the two lane registers and the
// output register. Throughput: one frame per cycle while rsp_tready is high,
// set by the two gain lanes, each with one multiply for the gain and one for
// the divide by the half-block length, every multiply in its own stage.
// Reset clears the configuration registers, the stage valid flags, the route
// state and the block position; the first frame after reset starts a block.
// When the receiver holds rsp_tready low, the output register holds its frame
// and the earlier stages keep filling; req_tready drops once all are full.
`default_nettype none
module cv_matrix_switch_soft_fade #(
   parameter int BLOCK_LEN = cvmsf_pkg::BLOCK_LEN_DEF
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   // in_ch0..in_ch7, cv_in_select, cv_out_select, 16 bits each from bit 0
   input  wire logic [(cvmsf_pkg::CHANNELS+2)*cvmsf_pkg::SAMPLE_W-1:0] req_tdata,
   input  wire logic                                              req_tvalid,
   output logic                                                   req_tready,
   // out_ch0..out_ch7, 16 bits each from bit 0
   output logic [cvmsf_pkg::CHANNELS*cvmsf_pkg::SAMPLE_W-1:0]     rsp_tdata,
   output logic                                                   rsp_tvalid,
   input  wire logic                                              rsp_tready,
   input  wire logic                                              csr_wr_en,
   input  wire logic [cvmsf_pkg::CSR_IDX_W-1:0]                   csr_index,
   input  wire logic [cvmsf_pkg::CSR_DATA_W-1:0]                  csr_wdata
);
   import cvmsf_pkg::*;

   localparam int HALF  = BLOCK_LEN / 2;
   localparam int NUM_W = $clog2(HALF + 1);
   localparam int POS_W = $clog2(BLOCK_LEN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LEN - 1);
   localparam logic [POS_W:0]   HALF_K   = (POS_W + 1)'(HALF);
   localparam logic [POS_W:0]   FULL_K   = (POS_W + 1)'(2 * HALF);

   // Configuration registers.
   logic signed [SAMPLE_W-1:0] in_ofs_ff;
   logic signed [SAMPLE_W-1:0] out_ofs_ff;
   logic                       active_ff;
   logic                       soft_ff;
   logic [CHANNELS-1:0]        in_mask_ff;
   logic [CHANNELS-1:0]        out_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ofs_ff   <= '0;
         out_ofs_ff  <= '0;
         active_ff   <= 1'b0;
         soft_ff     <= 1'b0;
         in_mask_ff  <= '0;
         out_mask_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IN_OFS:   in_ofs_ff   <= csr_wdata[SAMPLE_W-1:0];
            REG_OUT_OFS:  out_ofs_ff  <= csr_wdata[SAMPLE_W-1:0];
            REG_ACTIVE:   active_ff   <= csr_wdata[0];
            REG_SOFT:     soft_ff     <= csr_wdata[0];
            REG_IN_MASK:  in_mask_ff  <= csr_wdata[CHANNELS-1:0];
            REG_OUT_MASK: out_mask_ff <= csr_wdata[CHANNELS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Pipeline handshake: each stage loads when it is empty or moves on.
   logic a_valid_ff, b_valid_ff, c_valid_ff, o_valid_ff;
   logic a_valid_in, b_valid_in, c_valid_in, o_valid_in;
   logic load_a, load_o;
   logic ready_b, ready_c, ready_o;
   stage_en_type lane_en;

   always_comb begin
      ready_o        = !o_valid_ff || rsp_tready;
      load_o         = c_valid_ff && ready_o;
      ready_c        = !c_valid_ff || ready_o;
      lane_en.load_c = b_valid_ff && ready_c;
      ready_b        = !b_valid_ff || ready_c;
      lane_en.load_b = a_valid_ff && ready_b;
      req_tready     = !a_valid_ff || ready_b;
      load_a         = req_tvalid && req_tready;

      a_valid_in = load_a ? 1'b1 : (lane_en.load_b ? 1'b0 : a_valid_ff);
      b_valid_in = lane_en.load_b ? 1'b1 : (lane_en.load_c ? 1'b0 : b_valid_ff);
      c_valid_in = lane_en.load_c ? 1'b1 : (load_o ? 1'b0 : c_valid_ff);
      o_valid_in = load_o ? 1'b1 : (rsp_tready ? 1'b0 : o_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // Unpack the frame.
   logic signed [SAMPLE_W-1:0] smp [CHANNELS];
   logic signed [SAMPLE_W-1:0] cv_in_select;
   logic signed [SAMPLE_W-1:0] cv_out_select;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         smp[c] = req_tdata[c*SAMPLE_W +: SAMPLE_W];
      end
      cv_in_select  = req_tdata[CHANNELS*SAMPLE_W +: SAMPLE_W];
      cv_out_select = req_tdata[(CHANNELS+1)*SAMPLE_W +: SAMPLE_W];
   end

   // Source and destination picks for a block start.
   logic [CH_W-1:0] pick_src;
   logic [CH_W-1:0] pick_dst;

   cvmsf_pick u_pick_src (
      .offset_i      (in_ofs_ff),
      .cv_i          (cv_in_select),
      .mask_i        (in_mask_ff),
      .active_only_i (active_ff),
      .chan_o        (pick_src)
   );

   cvmsf_pick u_pick_dst (
      .offset_i      (out_ofs_ff),
      .cv_i          (cv_out_select),
      .mask_i        (out_mask_ff),
      .active_only_i (active_ff),
      .chan_o        (pick_dst)
   );

   // Block position and route state.
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CH_W-1:0]  cur_src_ff, cur_dst_ff, prev_src_ff, prev_dst_ff;
   logic [CH_W-1:0]  cur_src_in, cur_dst_in, prev_src_in, prev_dst_in;
   logic             fade_ff, fade_in;
   logic             block_start;

   always_comb begin
      block_start = (pos_ff == '0);
      pos_in      = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
      if (block_start) begin
         prev_src_in = cur_src_ff;
         prev_dst_in = cur_dst_ff;
         cur_src_in  = pick_src;
         cur_dst_in  = pick_dst;
         fade_in     = soft_ff && ((pick_src != cur_src_ff) || (pick_dst != cur_dst_ff));
      end else begin
         prev_src_in = prev_src_ff;
         prev_dst_in = prev_dst_ff;
         cur_src_in  = cur_src_ff;
         cur_dst_in  = cur_dst_ff;
         fade_in     = fade_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         cur_src_ff  <= '0;
         cur_dst_ff  <= '0;
         prev_src_ff <= '0;
         prev_dst_ff <= '0;
         fade_ff     <= 1'b0;
      end else if (load_a) begin
         pos_ff      <= pos_in;
         cur_src_ff  <= cur_src_in;
         cur_dst_ff  <= cur_dst_in;
         prev_src_ff <= prev_src_in;
         prev_dst_ff <= prev_dst_in;
         fade_ff     <= fade_in;
      end
   end

   // Route samples, gain numerators and output placement for this frame.
   logic [POS_W:0]             k_ext;
   logic                       first_half;
   logic                       second_half;
   logic signed [SAMPLE_W-1:0] new_smp_in, old_smp_in;
   logic [NUM_W-1:0]           num_new_in, num_old_in;
   route_ctl_type              ctl_in;

   always_comb begin
      k_ext       = {1'b0, pos_ff};
      first_half  = (k_ext < HALF_K);
      second_half = !first_half && (k_ext < FULL_K);

      new_smp_in = in_mask_ff[cur_src_in] ? smp[cur_src_in] : '0;
      old_smp_in = (fade_in && in_mask_ff[prev_src_in]) ? smp[prev_src_in] : '0;

      num_new_in = HALF_K[NUM_W-1:0];
      num_old_in = HALF_K[NUM_W-1:0];
      if (fade_in) begin
         if (first_half) begin
            num_new_in = '0;
            num_old_in = NUM_W'(HALF_K - k_ext);
         end else if (second_half) begin
            num_new_in = NUM_W'(k_ext - HALF_K);
            num_old_in = '0;
         end
      end

      ctl_in.cur_dest  = cur_dst_in;
      ctl_in.prev_dest = prev_dst_in;
      ctl_in.cur_en    = out_mask_ff[cur_dst_in];
      ctl_in.prev_en   = (cur_dst_in != prev_dst_in) && out_mask_ff[prev_dst_in];
      ctl_in.add_old   = (cur_src_in != prev_src_in) && first_half;
   end

   logic signed [SAMPLE_W-1:0] a_new_smp_ff, a_old_smp_ff;
   logic [NUM_W-1:0]           a_num_new_ff, a_num_old_ff;
   route_ctl_type              a_ctl_ff, b_ctl_ff, c_ctl_ff;

   always_ff @(posedge clock) begin
      if (load_a) begin
         a_new_smp_ff <= new_smp_in;
         a_old_smp_ff <= old_smp_in;
         a_num_new_ff <= num_new_in;
         a_num_old_ff <= num_old_in;
         a_ctl_ff     <= ctl_in;
      end
      if (lane_en.load_b) begin
         b_ctl_ff <= a_ctl_ff;
      end
      if (lane_en.load_c) begin
         c_ctl_ff <= b_ctl_ff;
      end
   end

   // One gain lane for the new route, one for the old.
   logic signed [SAMPLE_W:0] new_val, old_val;

   cvmsf_lane #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_lane_new (
      .clock    (clock),
      .en_i     (lane_en),
      .sample_i (a_new_smp_ff),
      .num_i    (a_num_new_ff),
      .value_o  (new_val)
   );

   cvmsf_lane #(
      .BLOCK_LEN (BLOCK_LEN)
   ) u_lane_old (
      .clock    (clock),
      .en_i     (lane_en),
      .sample_i (a_old_smp_ff),
      .num_i    (a_num_old_ff),
      .value_o  (old_val)
   );

   // Merge the lanes onto the output channels.
   logic [CHANNELS*SAMPLE_W-1:0] frame_in;
   logic [CHANNELS*SAMPLE_W-1:0] frame_ff;

   cvmsf_merge u_merge (
      .new_val_i (new_val),
      .old_val_i (old_val),
      .ctl_i     (c_ctl_ff),
      .frame_o   (frame_in)
   );

   always_ff @(posedge clock) begin
      if (load_o) begin
         frame_ff <= frame_in;
      end
   end

   assign rsp_tdata  = frame_ff;
   assign rsp_tvalid = o_valid_ff;

endmodule
`default_nettype wire
